FILE: rtl/fsrd_pkg.sv
// ----------------------------------------------------------------------------
// fsrd_pkg
// Shared types and constants of the flame sensor release delay reporter.
// ----------------------------------------------------------------------------
package fsrd_pkg;

  localparam int CHANNELS    = 3;
  localparam int CHANNEL_W   = 2;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] RELEASE_HOLD_RST = CFG_W'(2000);
  localparam logic [CFG_W-1:0] HEARTBEAT_RST    = CFG_W'(500);

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_LOW     = 2'd1,
    LVL_HIGH    = 2'd2
  } level_e;

  typedef struct packed {
    logic [CFG_W-1:0] release_hold;
    logic [CFG_W-1:0] heartbeat_interval;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0] emit;
    logic [CHANNELS-1:0] flame;
  } poll_rec_t;

endpackage

FILE: rtl/fsrd_if.sv
// ----------------------------------------------------------------------------
// fsrd interfaces
// Poll request channel and report channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsrd_poll_if;
  logic                                valid;
  logic                                ready;
  logic [fsrd_pkg::CHANNELS-1:0]       sensor_levels;
  logic [fsrd_pkg::TIME_W-1:0]         now_ms;

  modport source (output valid, output sensor_levels, output now_ms, input ready);
  modport sink   (input valid, input sensor_levels, input now_ms, output ready);
endinterface

interface fsrd_report_if;
  logic                                valid;
  logic                                ready;
  logic [fsrd_pkg::CHANNEL_W-1:0]      channel;
  logic                                flame;
  logic                                last_report;

  modport source (output valid, output channel, output flame, output last_report,
                  input ready);
  modport sink   (input valid, input channel, input flame, input last_report,
                  output ready);
endinterface

FILE: rtl/flame_sensor_release_delay_reporter_unit.sv
// ----------------------------------------------------------------------------
// flame_sensor_release_delay_reporter_unit
// Top level: configuration registers, front classifier, record queue and
// report sequencer.
// ----------------------------------------------------------------------------
// A poll request is accepted every cycle while the four-entry record queue has
// room; its state update and classification finish in the accepting cycle.
// Each poll yields zero to three reports, sent one per cycle by the back end
// while the report sink is ready, with the last one flagged; a poll with no
// reports never enters the queue, and each report passes through the queue
// entry, the back end's channel mask register and its output register.
// ----------------------------------------------------------------------------
module flame_sensor_release_delay_reporter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fsrd_poll_if.sink                     poll,
  fsrd_report_if.source                 report,
  input  logic                          cfg_we_i,
  input  logic [fsrd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsrd_pkg::CFG_W-1:0]    cfg_data_i
);
  import fsrd_pkg::*;

  cfg_t      cfg_q;
  poll_rec_t push_rec, head_rec;
  logic      push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_hold       <= RELEASE_HOLD_RST;
      cfg_q.heartbeat_interval <= HEARTBEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RELEASE_HOLD: cfg_q.release_hold       <= cfg_data_i;
        REG_HEARTBEAT:    cfg_q.heartbeat_interval <= cfg_data_i;
        default:          cfg_q                    <= cfg_q;
      endcase
    end
  end

  fsrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .poll        (poll),
    .fifo_full_i (full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  fsrd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (head_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  fsrd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_rec),
    .empty_i (empty),
    .pop_o   (pop),
    .report  (report)
  );

endmodule

FILE: rtl/fsrd_front.sv
// ----------------------------------------------------------------------------
// fsrd_front
// Accepts poll requests, updates per-channel debounce state and heartbeat,
// and classifies which channels report and with which flame value.
// ----------------------------------------------------------------------------
module fsrd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsrd_pkg::cfg_t      cfg_i,
  fsrd_poll_if.sink           poll,
  input  logic                fifo_full_i,
  output logic                push_o,
  output fsrd_pkg::poll_rec_t rec_o
);
  import fsrd_pkg::*;

  level_e                  level_q [CHANNELS];
  level_e                  level_d [CHANNELS];
  logic [TIME_W-1:0]       since_q [CHANNELS];
  logic [TIME_W-1:0]       since_d [CHANNELS];
  logic [CHANNELS-1:0]     run_q, run_d;
  logic [TIME_W-1:0]       last_hb_q, last_hb_d;
  logic [TIME_W-1:0]       hb_elapsed;
  logic                    due;
  logic                    accept;
  logic [TIME_W-1:0]       held [CHANNELS];

  assign poll.ready = !fifo_full_i;
  assign accept     = poll.valid && poll.ready;
  assign hb_elapsed = poll.now_ms - last_hb_q;
  assign due        = hb_elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg_i.heartbeat_interval};
  assign last_hb_d  = due ? poll.now_ms : last_hb_q;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      held[i]       = poll.now_ms - since_q[i];
      level_d[i]    = level_q[i];
      since_d[i]    = since_q[i];
      run_d[i]      = run_q[i];
      rec_o.emit[i]  = 1'b0;
      rec_o.flame[i] = 1'b0;
      if (!poll.sensor_levels[i]) begin
        rec_o.flame[i] = 1'b1;
        rec_o.emit[i]  = (level_q[i] != LVL_LOW) || due;
        level_d[i]     = LVL_LOW;
        run_d[i]       = 1'b0;
        since_d[i]     = '0;
      end else if (!run_q[i]) begin
        run_d[i]   = 1'b1;
        since_d[i] = poll.now_ms;
      end else if (held[i] >= {{(TIME_W-CFG_W){1'b0}}, cfg_i.release_hold} &&
                   level_q[i] != LVL_HIGH) begin
        rec_o.emit[i] = 1'b1;
        level_d[i]    = LVL_HIGH;
      end else if (due && level_q[i] == LVL_HIGH) begin
        rec_o.emit[i] = 1'b1;
      end
    end
  end

  assign push_o = accept && (|rec_o.emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= LVL_UNKNOWN;
        since_q[i] <= '0;
      end
      run_q     <= '0;
      last_hb_q <= '0;
    end else if (accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        level_q[i] <= level_d[i];
        since_q[i] <= since_d[i];
      end
      run_q     <= run_d;
      last_hb_q <= last_hb_d;
    end
  end

endmodule

FILE: rtl/fsrd_fifo.sv
// ----------------------------------------------------------------------------
// fsrd_fifo
// Short queue of classified poll records between front and back.
// ----------------------------------------------------------------------------
module fsrd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fsrd_pkg::poll_rec_t wdata_i,
  input  logic                pop_i,
  output fsrd_pkg::poll_rec_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import fsrd_pkg::*;

  poll_rec_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  count_q;
  logic                   do_push, do_pop;

  assign full_o  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
        2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/fsrd_back.sv
// ----------------------------------------------------------------------------
// fsrd_back
// Expands one poll record into its reports, lowest channel first, one per
// cycle while the report sink is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module fsrd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsrd_pkg::poll_rec_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  fsrd_report_if.source       report
);
  import fsrd_pkg::*;

  logic [CHANNELS-1:0]  mask_q, mask_d;
  logic [CHANNELS-1:0]  flame_q, flame_d;
  logic [CHANNELS-1:0]  sel_oh, rest, mask_after;
  logic [CHANNEL_W-1:0] sel_idx;
  logic                 advance;
  logic                 out_valid_q, out_valid_d;
  logic [CHANNEL_W-1:0] out_ch_q;
  logic                 out_flame_q, out_last_q;

  always_comb begin
    sel_oh  = '0;
    sel_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_oh  = '0;
        sel_oh[i] = 1'b1;
        sel_idx = CHANNEL_W'(i);
      end
    end
  end

  assign rest       = mask_q & ~sel_oh;
  assign advance    = (|mask_q) && (!out_valid_q || report.ready);
  assign mask_after = advance ? rest : mask_q;
  assign pop_o      = !empty_i && (mask_after == '0);
  assign mask_d     = pop_o ? head_i.emit : mask_after;
  assign flame_d    = pop_o ? head_i.flame : flame_q;

  always_comb begin
    priority if (advance)   out_valid_d = 1'b1;
    else if (report.ready)  out_valid_d = 1'b0;
    else                    out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flame_q <= flame_d;
    if (advance) begin
      out_ch_q    <= sel_idx;
      out_flame_q <= |(flame_q & sel_oh);
      out_last_q  <= rest == '0;
    end
  end

  assign report.valid       = out_valid_q;
  assign report.channel     = out_ch_q;
  assign report.flame       = out_flame_q;
  assign report.last_report = out_last_q;

endmodule

FILE: tb/flame_sensor_release_delay_reporter_unit_tb.sv
// ----------------------------------------------------------------------------
// flame_sensor_release_delay_reporter_unit_tb
// Drives poll requests through the flame reporter and checks every report
// against table expectations or a model of the per-channel debounce and heartbeat logic.
// A directed table covers reset, release timing, heartbeats and time wrap;
// random phases then follow under several register settings, with bursty
// polling, a stalling report sink and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module flame_sensor_release_delay_reporter_unit_tb;
  import fsrd_pkg::*;

  localparam int NUM_DIR      = 18;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_POLLS  = 18;
  localparam int DRAIN_CYC    = 12;
  localparam int PRESSURE_AT  = 40;
  localparam int PRESSURE_CYC = 80;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic                 flame;
    logic                 last_report;
  } report_t;

  typedef struct packed {
    logic [CHANNELS-1:0] lv;
    logic [TIME_W-1:0]   t;
    logic                fixed_exp;
    logic [1:0]          n_rpt;
    report_t             r0;
    report_t             r1;
    report_t             r2;
  } poll_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN
  } sink_mode_e;

  localparam report_t NO_RPT = '0;

  localparam poll_row_t DIR_TAB [NUM_DIR] = '{
    '{3'b100, 32'd0,    1'b1, 2'd2, '{2'd0, 1'b1, 1'b0}, '{2'd1, 1'b1, 1'b1}, NO_RPT},
    '{3'b100, 32'd600,  1'b1, 2'd2, '{2'd0, 1'b1, 1'b0}, '{2'd1, 1'b1, 1'b1}, NO_RPT},
    '{3'b100, 32'd2000, 1'b1, 2'd3, '{2'd0, 1'b1, 1'b0}, '{2'd1, 1'b1, 1'b0},
      '{2'd2, 1'b0, 1'b1}},
    '{3'b000, 32'd2100, 1'b1, 2'd1, '{2'd2, 1'b1, 1'b1}, NO_RPT, NO_RPT},
    '{3'b111, 32'd2200, 1'b1, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'd4199, 1'b1, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'd4200, 1'b1, 2'd3, '{2'd0, 1'b0, 1'b0}, '{2'd1, 1'b0, 1'b0},
      '{2'd2, 1'b0, 1'b1}},
    '{3'b111, 32'd4699, 1'b1, 2'd3, '{2'd0, 1'b0, 1'b0}, '{2'd1, 1'b0, 1'b0},
      '{2'd2, 1'b0, 1'b1}},
    '{3'b101, 32'd4700,       1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b010, 32'hFFFF_FFFF,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b010, 32'h0000_01F3,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'hFFFF_F000,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'h0000_0800,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'hFFFF_FFFF,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b000, 32'h7FFF_FFFF,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b111, 32'h8000_0000,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b110, 32'hFFFF_FFFE,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT},
    '{3'b011, 32'h0000_0001,  1'b0, 2'd0, NO_RPT, NO_RPT, NO_RPT}
  };

  localparam logic [CFG_W-1:0] HOLD_SET [NUM_PHASES - 1] = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFF};
  localparam logic [CFG_W-1:0] BEAT_SET [NUM_PHASES - 1] = '{16'd0, 16'd1, 16'hFFFF, 16'd1};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fsrd_poll_if   poll_bus ();
  fsrd_report_if rpt_bus ();

  flame_sensor_release_delay_reporter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .poll       (poll_bus),
    .report     (rpt_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  level_e            chan_lvl   [CHANNELS];
  logic [TIME_W-1:0] high_start [CHANNELS];
  bit                timer_on   [CHANNELS];
  logic [TIME_W-1:0] last_beat;
  logic [CFG_W-1:0]  hold_ms;
  logic [CFG_W-1:0]  beat_ms;

  report_t             pending_reports [$];
  int                  err_cnt;
  int                  polls_taken;
  int                  burst_left;
  logic [CHANNELS-1:0] lv_cur;
  logic [TIME_W-1:0]   t_cur;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_err(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic enqueue_report(input report_t r);
    pending_reports = {pending_reports, r};
  endtask

  function automatic int predict_reports(input logic [CHANNELS-1:0] lv,
                                         input logic [TIME_W-1:0] t,
                                         output report_t res [CHANNELS]);
    int   n;
    logic due;
    n = 0;
    due = (t - last_beat) >= TIME_W'(beat_ms);
    for (int i = 0; i < CHANNELS; i++) begin
      res[i] = NO_RPT;
      if (!lv[i]) begin
        if (chan_lvl[i] != LVL_LOW || due) begin
          res[n] = '{CHANNEL_W'(i), 1'b1, 1'b0};
          n++;
          chan_lvl[i] = LVL_LOW;
        end
        timer_on[i] = 1'b0;
        high_start[i] = '0;
      end else if (!timer_on[i]) begin
        timer_on[i] = 1'b1;
        high_start[i] = t;
      end else if ((t - high_start[i]) >= TIME_W'(hold_ms) && chan_lvl[i] != LVL_HIGH) begin
        res[n] = '{CHANNEL_W'(i), 1'b0, 1'b0};
        n++;
        chan_lvl[i] = LVL_HIGH;
      end else if (due && chan_lvl[i] == LVL_HIGH) begin
        res[n] = '{CHANNEL_W'(i), 1'b0, 1'b0};
        n++;
      end
    end
    if (due) last_beat = t;
    if (n > 0) res[n-1].last_report = 1'b1;
    return n;
  endfunction

  task automatic send_poll(input logic [CHANNELS-1:0] lv, input logic [TIME_W-1:0] t);
    poll_bus.valid         <= 1'b1;
    poll_bus.sensor_levels <= lv;
    poll_bus.now_ms        <= t;
    @(posedge clk_i);
    while (!poll_bus.ready) @(posedge clk_i);
    polls_taken++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        poll_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic predict_and_queue(input logic [CHANNELS-1:0] lv, input logic [TIME_W-1:0] t);
    report_t res [CHANNELS];
    int      n;
    n = predict_reports(lv, t, res);
    for (int k = 0; k < n; k++) enqueue_report(res[k]);
  endtask

  task automatic drain_phase();
    poll_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_cfg(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] beat);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RELEASE_HOLD;
    cfg_data_i <= hold;
    @(posedge clk_i);
    cfg_idx_i  <= REG_HEARTBEAT;
    cfg_data_i <= beat;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    hold_ms = hold;
    beat_ms = beat;
  endtask

  task automatic run_random(input int count);
    int span;
    int pick;
    t_cur = $urandom;
    lv_cur = CHANNELS'($urandom);
    repeat (count) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        t_cur = $urandom;
        lv_cur = CHANNELS'($urandom);
      end else begin
        span = (hold_ms > beat_ms) ? int'(hold_ms) : int'(beat_ms);
        if (span < 8) span = 8;
        t_cur = t_cur + TIME_W'($urandom_range(0, span / 2));
        if (pick < 4) lv_cur = lv_cur ^ CHANNELS'(1 << $urandom_range(0, CHANNELS - 1));
      end
      send_poll(lv_cur, t_cur);
      predict_and_queue(lv_cur, t_cur);
      pace_sender();
    end
  endtask

  initial begin
    sink_mode_e  mode;
    int          mode_left;
    int          stall_left;
    bit          held;
    logic [31:0] pat;
    report_t     want;
    mode_left = 0;
    stall_left = 0;
    held = 1'b0;
    pat = '0;
    mode = RDY_ALWAYS;
    rpt_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rpt_bus.valid && rpt_bus.ready) begin
        if (pending_reports.size() == 0) begin
          report_err($sformatf("unexpected report ch %0d flame %0d",
                               rpt_bus.channel, rpt_bus.flame));
        end else begin
          want = pending_reports.pop_front();
          if (rpt_bus.channel !== want.channel)
            report_err($sformatf("channel got %0d want %0d", rpt_bus.channel, want.channel));
          if (rpt_bus.flame !== want.flame)
            report_err($sformatf("flame on ch %0d got %0d want %0d",
                                 want.channel, rpt_bus.flame, want.flame));
          if (rpt_bus.last_report !== want.last_report)
            report_err($sformatf("last_report on ch %0d got %0d want %0d",
                                 want.channel, rpt_bus.last_report, want.last_report));
        end
      end
      if (!held && polls_taken >= PRESSURE_AT) begin
        held = 1'b1;
        stall_left = PRESSURE_CYC;
      end
      if (stall_left > 0) begin
        stall_left--;
        rpt_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 40);
          pat = $urandom;
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS: begin
            rpt_bus.ready <= 1'b1;
          end
          RDY_COIN: begin
            rpt_bus.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            rpt_bus.ready <= pat[0];
            pat = {pat[0], pat[31:1]};
          end
        endcase
      end
    end
  end

  initial begin
    report_t   res [CHANNELS];
    report_t   fixed [CHANNELS];
    poll_row_t row;
    int        n;
    err_cnt = 0;
    polls_taken = 0;
    burst_left = 0;
    poll_bus.valid = 1'b0;
    poll_bus.sensor_levels = '0;
    poll_bus.now_ms = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_RELEASE_HOLD;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_lvl[i] = LVL_UNKNOWN;
      high_start[i] = '0;
      timer_on[i] = 1'b0;
    end
    last_beat = '0;
    hold_ms = RELEASE_HOLD_RST;
    beat_ms = HEARTBEAT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      row = DIR_TAB[r];
      send_poll(row.lv, row.t);
      if (row.fixed_exp) begin
        n = predict_reports(row.lv, row.t, res);
        fixed[0] = row.r0;
        fixed[1] = row.r1;
        fixed[2] = row.r2;
        for (int k = 0; k < int'(row.n_rpt); k++) enqueue_report(fixed[k]);
      end else begin
        predict_and_queue(row.lv, row.t);
      end
      pace_sender();
    end
    drain_phase();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES - 1)
        set_cfg(HOLD_SET[p], BEAT_SET[p]);
      else
        set_cfg(CFG_W'($urandom_range(1, 3000)), CFG_W'($urandom_range(1, 1500)));
      run_random(PHASE_POLLS);
      drain_phase();
    end

    if (pending_reports.size() != 0)
      report_err($sformatf("%0d reports never arrived", pending_reports.size()));
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("FAILURE");
    $finish;
  end

endmodule
